### rtl/swam_pkg.sv
// Package for the sliding window mean/min/max block.
// Holds the sequencer state type and the fixed field widths.
// No dependencies.
package swam_pkg;

    localparam int LEN_BITS  = 11;
    localparam int TIME_BITS = 31;
    localparam int NUM_AXES  = 3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_WAIT = 3'b100
    } t_state;

endpackage

### rtl/swam_div.sv
// Radix-2 restoring divider: signed dividend by unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// Standalone; used by sliding_window_avg_minmax.
module swam_div #(
    parameter int DVD_BITS = 26,
    parameter int DVS_BITS = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [DVD_BITS-1:0] i_dividend,
    input  logic        [DVS_BITS-1:0] i_divisor,
    output logic                       o_done,
    output logic signed [DVD_BITS-1:0] o_quotient
);

    localparam int CNT_BITS = $clog2(DVD_BITS + 1);

    logic                r_busy;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DVD_BITS-1:0] r_mag;
    logic [DVS_BITS-1:0] r_rem;
    logic [DVS_BITS-1:0] r_dvs;
    logic                r_neg;

    logic [DVS_BITS:0]   n_trial;
    logic                n_qbit;
    logic [DVS_BITS-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_mag[DVD_BITS-1]};
        n_qbit  = (n_trial >= {1'b0, r_dvs});
        if (n_qbit) begin
            n_rem = DVS_BITS'(n_trial - {1'b0, r_dvs});
        end else begin
            n_rem = n_trial[DVS_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(DVD_BITS);
            r_neg  <= i_dividend[DVD_BITS-1];
            r_mag  <= i_dividend[DVD_BITS-1] ? DVD_BITS'(-i_dividend) : i_dividend;
            r_dvs  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_mag <= {r_mag[DVD_BITS-2:0], n_qbit};
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done     = !r_busy;
    assign o_quotient = r_neg ? DVD_BITS'(-$signed(r_mag)) : $signed(r_mag);

endmodule

### rtl/sliding_window_avg_minmax.sv
// Sliding window mean / min / max over three accelerometer axes.
// Window samples live in one synchronous RAM; means come from swam_div.
// Depends on swam_pkg and swam_div.
//
//  channel  handshake                  payload
//  input    i_in_valid / o_in_stall    i_sample_time, i_accel_x/y/z
//  result   o_out_valid / i_out_stall  o_result_time, o_mean/min/max_x/y/z
//  config   i_cfg_we                   i_cfg_data (window length)
//
// A fill-phase request only writes the RAM and the running sums. A request that
// gives a result scans the window: the RAM read port walks the window one entry
// a cycle while the three dividers run.
// Reset is synchronous; the RAM needs no clearing, the fill count guards it.
// A stalled result waits in the output register; the next request is taken
// meanwhile and finishes once the register is free.
module sliding_window_avg_minmax #(
    parameter int WINDOW_MAX  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [swam_pkg::LEN_BITS-1:0]        i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [swam_pkg::TIME_BITS-1:0]       i_sample_time,
    input  logic signed [SAMPLE_BITS-1:0]        i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0]        i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0]        i_accel_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [swam_pkg::TIME_BITS-1:0]       o_result_time,
    output logic signed [SAMPLE_BITS-1:0]        o_mean_x,
    output logic signed [SAMPLE_BITS-1:0]        o_min_x,
    output logic signed [SAMPLE_BITS-1:0]        o_max_x,
    output logic signed [SAMPLE_BITS-1:0]        o_mean_y,
    output logic signed [SAMPLE_BITS-1:0]        o_min_y,
    output logic signed [SAMPLE_BITS-1:0]        o_max_y,
    output logic signed [SAMPLE_BITS-1:0]        o_mean_z,
    output logic signed [SAMPLE_BITS-1:0]        o_min_z,
    output logic signed [SAMPLE_BITS-1:0]        o_max_z
);

    import swam_pkg::*;

    localparam int AW       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LW       = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
    localparam int WORD     = NUM_AXES * SAMPLE_BITS;

    logic [WORD-1:0] mem [WINDOW_MAX];

    t_state                      r_state;
    logic [LW-1:0]               r_len;
    logic [LW-1:0]               r_fill;
    logic [AW-1:0]               r_wp;
    logic signed [SUM_BITS-1:0]  r_sum [NUM_AXES];
    logic [TIME_BITS-1:0]        r_time;
    logic [WORD-1:0]             r_smp;
    logic [AW-1:0]               r_addr;
    logic [LW-1:0]               r_rem;
    logic                        r_fst;
    logic                        r_dv;
    logic                        r_dlast;
    logic                        r_dfirst;
    logic [WORD-1:0]             r_rdata;
    logic [WORD-1:0]             r_old;
    logic signed [SAMPLE_BITS-1:0] r_min [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] r_max [NUM_AXES];
    logic                        r_out_valid;
    logic [TIME_BITS-1:0]        r_out_time;
    logic signed [SAMPLE_BITS-1:0] r_out_mean [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] r_out_min [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] r_out_max [NUM_AXES];

    logic                        accept;
    logic                        full;
    logic                        rd_en;
    logic                        fin;
    logic                        mem_we;
    logic [WORD-1:0]             mem_wdata;
    logic [WORD-1:0]             in_word;
    logic [LW-1:0]               n_len;
    logic [AW-1:0]               n_wp;
    logic [AW-1:0]               n_addr;
    logic                        div_start;
    logic [NUM_AXES-1:0]         div_done;
    logic signed [SUM_BITS-1:0]  div_q [NUM_AXES];

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_fill >= r_len);
    assign rd_en      = (r_state == ST_SCAN) && (r_rem != '0);
    assign fin        = (r_state == ST_WAIT) && (&div_done)
                        && (!r_out_valid || !i_out_stall);
    assign div_start  = accept && full;
    assign in_word    = {i_accel_z, i_accel_y, i_accel_x};
    assign mem_we     = (accept && !full) || fin;
    assign mem_wdata  = fin ? r_smp : in_word;
    assign n_wp       = (r_wp == AW'(WINDOW_MAX - 1)) ? '0 : r_wp + 1'b1;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_len = LW'(1);
        end else if (32'(i_cfg_data) > 32'(WINDOW_MAX)) begin
            n_len = LW'(WINDOW_MAX);
        end else begin
            n_len = LW'(i_cfg_data);
        end
    end

    // step one entry back in the circular store
    always_comb begin
        if (r_state == ST_IDLE) begin
            n_addr = (r_wp == '0) ? AW'(WINDOW_MAX - 1) : r_wp - 1'b1;
        end else begin
            n_addr = (r_addr == '0) ? AW'(WINDOW_MAX - 1) : r_addr - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wp] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[r_addr];
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_div
        swam_div #(
            .DVD_BITS (SUM_BITS),
            .DVS_BITS (LW)
        ) u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (r_sum[a]),
            .i_divisor  (r_len),
            .o_done     (div_done[a]),
            .o_quotient (div_q[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= LW'(1);
            r_fill      <= '0;
            r_wp        <= '0;
            r_rem       <= '0;
            r_fst       <= 1'b0;
            r_dv        <= 1'b0;
            r_dlast     <= 1'b0;
            r_dfirst    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            r_dv     <= rd_en;
            r_dlast  <= rd_en && (r_rem == LW'(1));
            r_dfirst <= rd_en && r_fst;

            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_len  <= n_len;
                r_fill <= '0;
                r_wp   <= '0;
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_sum[a] <= '0;
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_time <= i_sample_time;
                        r_smp  <= in_word;
                        if (full) begin
                            r_addr  <= n_addr;
                            r_rem   <= r_len;
                            r_fst   <= 1'b1;
                            r_state <= ST_SCAN;
                        end else begin
                            r_fill <= r_fill + 1'b1;
                            r_wp   <= n_wp;
                            for (int a = 0; a < NUM_AXES; a++) begin
                                r_sum[a] <= r_sum[a] + SUM_BITS'($signed(
                                            in_word[a*SAMPLE_BITS +: SAMPLE_BITS]));
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (rd_en) begin
                        r_addr <= n_addr;
                        r_rem  <= r_rem - 1'b1;
                        r_fst  <= 1'b0;
                    end
                    if (r_dv && r_dlast) begin
                        r_old   <= r_rdata;
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (fin) begin
                        r_wp    <= n_wp;
                        r_state <= ST_IDLE;
                        for (int a = 0; a < NUM_AXES; a++) begin
                            r_sum[a] <= r_sum[a]
                                - SUM_BITS'($signed(r_old[a*SAMPLE_BITS +: SAMPLE_BITS]))
                                + SUM_BITS'($signed(r_smp[a*SAMPLE_BITS +: SAMPLE_BITS]));
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // running extrema over the read stream
    always_ff @(posedge i_clk) begin
        if (r_dv) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                if (r_dfirst ||
                    $signed(r_rdata[a*SAMPLE_BITS +: SAMPLE_BITS]) < r_min[a]) begin
                    r_min[a] <= $signed(r_rdata[a*SAMPLE_BITS +: SAMPLE_BITS]);
                end
                if (r_dfirst ||
                    $signed(r_rdata[a*SAMPLE_BITS +: SAMPLE_BITS]) > r_max[a]) begin
                    r_max[a] <= $signed(r_rdata[a*SAMPLE_BITS +: SAMPLE_BITS]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_out_time <= r_time;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_out_mean[a] <= div_q[a][SAMPLE_BITS-1:0];
                r_out_min[a]  <= r_min[a];
                r_out_max[a]  <= r_max[a];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_time = r_out_time;
    assign o_mean_x      = r_out_mean[0];
    assign o_min_x       = r_out_min[0];
    assign o_max_x       = r_out_max[0];
    assign o_mean_y      = r_out_mean[1];
    assign o_min_y       = r_out_min[1];
    assign o_max_y       = r_out_max[1];
    assign o_mean_z      = r_out_mean[2];
    assign o_min_z       = r_out_min[2];
    assign o_max_z       = r_out_max[2];

endmodule

### tb/swam_checker.sv
`timescale 1ns / 1ps
// Checker for sliding_window_avg_minmax: tracks the window per request, predicts
// mean/min/max per axis and compares each accepted result. Depends on swam_pkg.
module swam_checker #(
    parameter int WINDOW_MAX  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [swam_pkg::LEN_BITS-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [swam_pkg::TIME_BITS-1:0]    i_sample_time,
    input  logic signed [SAMPLE_BITS-1:0]     i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0]     i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0]     i_accel_z,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [swam_pkg::TIME_BITS-1:0]    i_result_time,
    input  logic signed [SAMPLE_BITS-1:0]     i_mean_x,
    input  logic signed [SAMPLE_BITS-1:0]     i_min_x,
    input  logic signed [SAMPLE_BITS-1:0]     i_max_x,
    input  logic signed [SAMPLE_BITS-1:0]     i_mean_y,
    input  logic signed [SAMPLE_BITS-1:0]     i_min_y,
    input  logic signed [SAMPLE_BITS-1:0]     i_max_y,
    input  logic signed [SAMPLE_BITS-1:0]     i_mean_z,
    input  logic signed [SAMPLE_BITS-1:0]     i_min_z,
    input  logic signed [SAMPLE_BITS-1:0]     i_max_z,
    output int                                o_fail_count,
    output int                                o_pending
);

    typedef struct packed {
        logic [swam_pkg::TIME_BITS-1:0]               stamp;
        logic [swam_pkg::NUM_AXES-1:0][SAMPLE_BITS-1:0] mean;
        logic [swam_pkg::NUM_AXES-1:0][SAMPLE_BITS-1:0] lo;
        logic [swam_pkg::NUM_AXES-1:0][SAMPLE_BITS-1:0] hi;
    } t_window_stats;

    logic signed [SAMPLE_BITS-1:0] win_mem [swam_pkg::NUM_AXES][WINDOW_MAX];
    logic signed [25:0]            axis_sum [swam_pkg::NUM_AXES];
    logic [swam_pkg::LEN_BITS-1:0] win_len = 1;
    int                            wr_ptr = 0;
    int                            fill_cnt = 0;
    int                            fail_cnt = 0;
    t_window_stats                 stats_q [$];
    t_window_stats                 want;

    function automatic int eff_len(input logic [swam_pkg::LEN_BITS-1:0] v);
        if (v == 0) return 1;
        if (v > WINDOW_MAX) return WINDOW_MAX;
        return int'(v);
    endfunction

    task automatic clear_window();
        for (int a = 0; a < swam_pkg::NUM_AXES; a++) axis_sum[a] = '0;
        wr_ptr   = 0;
        fill_cnt = 0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_cnt++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0d expected %0d (stamp %0d)",
                                      name, got, exp_val, want.stamp));
    endtask

    task automatic take_request(input logic [swam_pkg::TIME_BITS-1:0] stamp,
                                input logic signed [SAMPLE_BITS-1:0] sx,
                                input logic signed [SAMPLE_BITS-1:0] sy,
                                input logic signed [SAMPLE_BITS-1:0] sz);
        int                            len;
        int                            wp;
        int                            total;
        logic signed [SAMPLE_BITS-1:0] smp [swam_pkg::NUM_AXES];
        logic signed [SAMPLE_BITS-1:0] v;
        logic signed [SAMPLE_BITS-1:0] lo;
        logic signed [SAMPLE_BITS-1:0] hi;
        t_window_stats                 st;
        len    = eff_len(win_len);
        wp     = wr_ptr;
        smp[0] = sx;
        smp[1] = sy;
        smp[2] = sz;
        if (fill_cnt >= len) begin
            st.stamp = stamp;
            for (int a = 0; a < swam_pkg::NUM_AXES; a++) begin
                lo = win_mem[a][(wp + WINDOW_MAX - 1) % WINDOW_MAX];
                hi = lo;
                for (int k = 2; k <= len; k++) begin
                    v = win_mem[a][(wp + WINDOW_MAX - k) % WINDOW_MAX];
                    if (v < lo) lo = v;
                    if (v > hi) hi = v;
                end
                total      = axis_sum[a];
                st.mean[a] = SAMPLE_BITS'(total / len);
                st.lo[a]   = lo;
                st.hi[a]   = hi;
            end
            stats_q.push_back(st);
            for (int a = 0; a < swam_pkg::NUM_AXES; a++)
                axis_sum[a] = axis_sum[a] - win_mem[a][(wp + WINDOW_MAX - len) % WINDOW_MAX];
        end else begin
            fill_cnt++;
        end
        for (int a = 0; a < swam_pkg::NUM_AXES; a++) begin
            win_mem[a][wp] = smp[a];
            axis_sum[a]    = axis_sum[a] + smp[a];
        end
        wr_ptr = (wp + 1) % WINDOW_MAX;
    endtask

    // results are compared before this edge's request is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_len = 1;
            clear_window();
            stats_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (stats_q.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending (stamp %0d)",
                                              i_result_time));
                end else begin
                    want = stats_q.pop_front();
                    check_field("result_time", i_result_time, want.stamp);
                    check_field("mean_x", i_mean_x, $signed(want.mean[0]));
                    check_field("min_x", i_min_x, $signed(want.lo[0]));
                    check_field("max_x", i_max_x, $signed(want.hi[0]));
                    check_field("mean_y", i_mean_y, $signed(want.mean[1]));
                    check_field("min_y", i_min_y, $signed(want.lo[1]));
                    check_field("max_y", i_max_y, $signed(want.hi[1]));
                    check_field("mean_z", i_mean_z, $signed(want.mean[2]));
                    check_field("min_z", i_min_z, $signed(want.lo[2]));
                    check_field("max_z", i_max_z, $signed(want.hi[2]));
                end
            end
            if (i_cfg_we) begin
                win_len = i_cfg_data;
                clear_window();
            end
            if (i_in_valid && !i_in_stall)
                take_request(i_sample_time, i_accel_x, i_accel_y, i_accel_z);
        end
        o_pending    <= stats_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the sliding_window_avg_minmax testbench: clock, reset, request and
// config stimulus, result stall, verdict. Depends on swam_pkg, sliding_window_avg_minmax and swam_checker.
module testbench;

    localparam int WINDOW_MAX  = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [swam_pkg::LEN_BITS-1:0]     cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [swam_pkg::TIME_BITS-1:0]    sample_time = '0;
    logic signed [SAMPLE_BITS-1:0]     accel_x = '0;
    logic signed [SAMPLE_BITS-1:0]     accel_y = '0;
    logic signed [SAMPLE_BITS-1:0]     accel_z = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [swam_pkg::TIME_BITS-1:0]    result_time;
    logic signed [SAMPLE_BITS-1:0]     mean_x, min_x, max_x;
    logic signed [SAMPLE_BITS-1:0]     mean_y, min_y, max_y;
    logic signed [SAMPLE_BITS-1:0]     mean_z, min_z, max_z;

    int                                fail_count;
    int                                pending;
    int                                cur_len = 1;
    int                                send_idle_pct = 23;
    int                                recv_idle_pct = 69;
    logic                              hold_kick = 1'b0;
    int                                hold_left = 0;
    int                                cycle_cnt = 0;
    logic [swam_pkg::TIME_BITS-1:0]    stamp_ctr = '0;

    sliding_window_avg_minmax #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_sample_time (sample_time),
        .i_accel_x     (accel_x),
        .i_accel_y     (accel_y),
        .i_accel_z     (accel_z),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_result_time (result_time),
        .o_mean_x      (mean_x),
        .o_min_x       (min_x),
        .o_max_x       (max_x),
        .o_mean_y      (mean_y),
        .o_min_y       (min_y),
        .o_max_y       (max_y),
        .o_mean_z      (mean_z),
        .o_min_z       (min_z),
        .o_max_z       (max_z)
    );

    swam_checker #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) stats_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_sample_time (sample_time),
        .i_accel_x     (accel_x),
        .i_accel_y     (accel_y),
        .i_accel_z     (accel_z),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_result_time (result_time),
        .i_mean_x      (mean_x),
        .i_min_x       (min_x),
        .i_max_x       (max_x),
        .i_mean_y      (mean_y),
        .i_min_y       (min_y),
        .i_max_y       (max_y),
        .i_mean_z      (mean_z),
        .i_min_z       (min_z),
        .i_max_z       (max_z),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side: random stall, or a long hold-off after a kick
    always @(posedge clk) begin
        if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        out_stall <= hold_kick || (hold_left > 1) || ($urandom_range(99) < recv_idle_pct);
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("[sliding_window_avg_minmax] ERROR");
        $finish;
    end

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4, 5: return 16'($urandom_range(16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [swam_pkg::TIME_BITS-1:0] next_stamp();
        if ($urandom_range(15) == 0) stamp_ctr = 31'($urandom);
        else stamp_ctr = stamp_ctr + 31'($urandom_range(1, 5000));
        return stamp_ctr;
    endfunction

    task automatic send_item(input logic [swam_pkg::TIME_BITS-1:0] t,
                             input logic [SAMPLE_BITS-1:0] x,
                             input logic [SAMPLE_BITS-1:0] y,
                             input logic [SAMPLE_BITS-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_time <= t;
        accel_x     <= x;
        accel_y     <= y;
        accel_z     <= z;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // fill-phase requests leave no result to wait on, so give the block its latency
    task automatic wait_idle();
        drain();
        repeat (cur_len + 64) @(posedge clk);
    endtask

    task automatic write_len(input logic [swam_pkg::LEN_BITS-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_len = (v == 0) ? 1 : ((v > WINDOW_MAX) ? WINDOW_MAX : int'(v));
    endtask

    task automatic run_phase(input logic [swam_pkg::LEN_BITS-1:0] len_val, input int n_res,
                             input bit hold, input bit drain_mid);
        int total;
        write_len(len_val);
        if (hold) begin
            hold_kick <= 1'b1;
            @(posedge clk);
            hold_kick <= 1'b0;
        end
        total = cur_len + n_res;
        for (int i = 0; i < total; i++) begin
            if (drain_mid && i == total / 2) drain();
            send_item(next_stamp(), pick_sample(), pick_sample(), pick_sample());
        end
        wait_idle();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // length 1 from reset: each result is the previous request's sample
        send_item(31'd0, 16'h7FFF, 16'h8000, 16'h0000);
        send_item(31'h7FFFFFFF, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_item(31'd1, 16'hFFFF, 16'h0001, 16'h7FFF);
        send_item(31'd2, 16'h0000, 16'h0000, 16'h8000);
        send_item(31'h40000000, 16'h5555, 16'hAAAA, 16'h0F0F);
        send_item(31'h2AAAAAAA, 16'hAAAA, 16'h5555, 16'hF0F0);
        wait_idle();

        // zero length acts as one
        write_len(11'd0);
        send_item(31'd10, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(31'd11, 16'h8000, 16'h8000, 16'h8000);
        send_item(31'd12, 16'h0001, 16'hFFFE, 16'h0000);
        wait_idle();

        // length 2: means truncate toward zero
        write_len(11'd2);
        send_item(31'd20, 16'h7FFF, 16'h8000, 16'h0001);
        send_item(31'd21, 16'h8000, 16'h8001, 16'hFFFE);
        send_item(31'd22, 16'h8000, 16'h7FFE, 16'hFFFD);
        send_item(31'd23, 16'h8001, 16'h7FFF, 16'h0003);
        send_item(31'd24, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_item(31'd25, 16'h7FFE, 16'h0000, 16'hFFFF);
        send_item(31'd26, 16'h0000, 16'h8000, 16'h0000);
        send_item(31'd27, 16'hFFFF, 16'h8000, 16'h0002);
        wait_idle();

        write_len(11'd3);
        send_item(31'd30, 16'h8000, 16'h0005, 16'h7FFF);
        send_item(31'd31, 16'h0002, 16'hFFFB, 16'h7FFF);
        send_item(31'd32, 16'h7FFF, 16'h0000, 16'h7FFF);
        send_item(31'd33, 16'hFFFF, 16'h0001, 16'h8000);
        send_item(31'd34, 16'h0001, 16'hFFFF, 16'h0000);
        wait_idle();

        run_phase(11'd32, 6, 1'b0, 1'b0);
        run_phase(11'd3, 20, 1'b0, 1'b0);
        run_phase(11'd17, 20, 1'b0, 1'b0);
        run_phase(11'($urandom_range(1, 40)), 20, 1'b0, 1'b0);

        send_idle_pct = 69;
        recv_idle_pct <= 23;
        run_phase(11'd40, 6, 1'b0, 1'b0);
        run_phase(11'd2, 30, 1'b1, 1'b0);
        run_phase(11'd1, 20, 1'b0, 1'b0);
        run_phase(11'd5, 30, 1'b0, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_phase(11'd0, 20, 1'b0, 1'b0);
        run_phase(11'd1, 20, 1'b0, 1'b0);
        run_phase(11'd8, 20, 1'b0, 1'b0);
        run_phase(11'($urandom_range(1, 40)), 20, 1'b1, 1'b0);

        if (fail_count == 0) begin
            $display("[sliding_window_avg_minmax] OK");
        end else begin
            $display("[sliding_window_avg_minmax] ERROR");
        end
        $finish;
    end

endmodule
